[src/srtf_pkg.sv]
// Shared types and constants of the shortest-remaining-time scheduler.
package srtf_pkg;

	// Field widths of the stream payloads.
	localparam int ARRIVAL_W = 32;
	localparam int BURST_W = 16;
	localparam int QUANTUM_W = 8;
	localparam int CLOCK_W = 32;
	localparam int SUM_W = 40;
	localparam int STATUS_W = 3;
	localparam int TASK_INDEX_W = 6;
	localparam int UNFINISHED_W = 7;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 216;

	// Quantum after reset.
	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

	// Command codes carried on the input tuser.
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Result status codes carried on the output tuser.
	localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PREEMPTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ALL_DONE = 3'd5;

	// Best-candidate record handed from cell to cell during a search.
	typedef struct packed {
		logic found;
		logic [BURST_W-1:0] left;
		logic [ARRIVAL_W-1:0] arrival;
		logic [BURST_W-1:0] burst;
	} token_t;

	// Write command broadcast to the cells; the slot index travels beside it.
	typedef struct packed {
		logic en;
		logic load;
		logic [ARRIVAL_W-1:0] arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] left;
	} cell_cmd_t;

endpackage

[src/srtf_quantum_scheduler.sv]
// Shortest-remaining-time-first scheduler with a quantum, built on a row of slot cells.
// An add or an all-done step goes from idle straight to the done state, which loads the output register;
// a scheduling step first walks the search, run and advance states, and on finish also turn, wait and sum.
// One item at a time: the next input is taken only once the done state has handed its result to the
// output register, and the done state stalls while that register still holds an untaken result;
// a scheduling step is held up by the candidate walking the MAX_TASKS-cell row.
// A new input is taken while the previous result still waits on the output register.
// Reset clears the clock, counters, totals and handshakes and sets the quantum to 4.
module srtf_quantum_scheduler #(
	parameter int MAX_TASKS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [srtf_pkg::QUANTUM_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// [31:0] arrival_tick, [47:32] burst_length
	input logic [srtf_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] command
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// [5:0] task_index, [37:6] start_tick, [45:38] slice_length, [61:46] left_after,
	// [93:62] waiting_ticks, [125:94] turnaround_ticks, [132:126] unfinished_count,
	// [172:133] total_waiting, [212:173] total_turnaround, [215:213] zero
	output logic [srtf_pkg::M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [srtf_pkg::STATUS_W-1:0] m_tuser
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_RUN = 4'd2;
	localparam logic [3:0] S_ADV = 4'd3;
	localparam logic [3:0] S_TURN = 4'd4;
	localparam logic [3:0] S_WAIT = 4'd5;
	localparam logic [3:0] S_SUM = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;

	logic [3:0] state_q;
	logic [IDX_W-1:0] search_cnt_q;
	logic [srtf_pkg::QUANTUM_W-1:0] quantum_q;
	logic [CNT_W-1:0] task_count_q;
	logic [CNT_W-1:0] open_count_q;
	logic [srtf_pkg::CLOCK_W-1:0] clock_q;
	logic [srtf_pkg::SUM_W-1:0] sum_wait_q;
	logic [srtf_pkg::SUM_W-1:0] sum_turn_q;

	// Per-item working registers.
	logic found_q;
	logic [srtf_pkg::QUANTUM_W-1:0] run_q;
	logic [srtf_pkg::BURST_W-1:0] left_new_q;
	logic [srtf_pkg::ARRIVAL_W-1:0] best_arr_q;
	logic [srtf_pkg::BURST_W-1:0] best_burst_q;
	logic [srtf_pkg::CLOCK_W-1:0] start_q;
	logic [srtf_pkg::STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [srtf_pkg::QUANTUM_W-1:0] res_slice_q;
	logic [srtf_pkg::BURST_W-1:0] res_left_q;
	logic [srtf_pkg::CLOCK_W-1:0] res_wait_q;
	logic [srtf_pkg::CLOCK_W-1:0] res_turn_q;

	// Output register.
	logic out_valid_q;
	logic [srtf_pkg::M_TDATA_W-1:0] out_tdata_q;
	logic [srtf_pkg::STATUS_W-1:0] out_tuser_q;

	logic in_xfer;
	logic out_free;
	logic table_full;
	logic [srtf_pkg::ARRIVAL_W-1:0] in_arrival;
	logic [srtf_pkg::BURST_W-1:0] in_burst;
	logic [srtf_pkg::QUANTUM_W-1:0] q_eff;
	logic [srtf_pkg::QUANTUM_W-1:0] run_d;
	logic [srtf_pkg::CLOCK_W:0] clock_sum;
	logic [srtf_pkg::CLOCK_W-1:0] clock_next;
	logic [srtf_pkg::SUM_W:0] wait_sum;
	logic [srtf_pkg::SUM_W:0] turn_sum;
	srtf_pkg::cell_cmd_t cell_cmd;
	logic [IDX_W-1:0] cell_cmd_idx;

	srtf_pkg::token_t chain_tok [MAX_TASKS+1];
	logic [IDX_W-1:0] chain_idx [MAX_TASKS+1];

	assign in_arrival = s_tdata[31:0];
	assign in_burst = s_tdata[47:32];
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign table_full = (task_count_q == CNT_W'(MAX_TASKS));

	// Row of slot cells; the best candidate moves one cell per cycle.
	assign chain_tok[0] = '0;
	assign chain_idx[0] = '0;

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		srtf_cell #(
			.IDX_W(IDX_W),
			.CNT_W(CNT_W),
			.MY_IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cell_cmd),
			.cmd_idx(cell_cmd_idx),
			.task_count(task_count_q),
			.clock_ticks(clock_q),
			.tok_in(chain_tok[g]),
			.idx_in(chain_idx[g]),
			.tok_out(chain_tok[g+1]),
			.idx_out(chain_idx[g+1])
		);
	end

	// Slot writes: an add fills the next free slot, a run updates the chosen one.
	always_comb begin
		cell_cmd = '0;
		cell_cmd_idx = task_count_q[IDX_W-1:0];
		if (in_xfer && (s_tuser == srtf_pkg::CMD_ADD) && !table_full) begin
			cell_cmd.en = 1'b1;
			cell_cmd.load = 1'b1;
			cell_cmd.arrival = in_arrival;
			cell_cmd.burst = in_burst;
			cell_cmd.left = in_burst;
		end else if ((state_q == S_ADV) && found_q) begin
			cell_cmd.en = 1'b1;
			cell_cmd.left = left_new_q;
			cell_cmd_idx = res_idx_q;
		end
	end

	// Slice length: the smaller of the quantum (zero acts as one) and the time left.
	always_comb begin
		q_eff = (quantum_q == '0) ? srtf_pkg::QUANTUM_W'(1) : quantum_q;
		if (chain_tok[MAX_TASKS].left < {{(srtf_pkg::BURST_W - srtf_pkg::QUANTUM_W){1'b0}}, q_eff}) begin
			run_d = chain_tok[MAX_TASKS].left[srtf_pkg::QUANTUM_W-1:0];
		end else begin
			run_d = q_eff;
		end
	end

	// Saturating clock advance and saturating totals.
	always_comb begin
		clock_sum = {1'b0, clock_q} + (srtf_pkg::CLOCK_W + 1)'(run_q);
		clock_next = clock_sum[srtf_pkg::CLOCK_W] ? '1 : clock_sum[srtf_pkg::CLOCK_W-1:0];
		wait_sum = {1'b0, sum_wait_q} + (srtf_pkg::SUM_W + 1)'(res_wait_q);
		turn_sum = {1'b0, sum_turn_q} + (srtf_pkg::SUM_W + 1)'(res_turn_q);
	end

	// Quantum register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= srtf_pkg::QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// Sequencer and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			search_cnt_q <= '0;
			task_count_q <= '0;
			open_count_q <= '0;
			clock_q <= '0;
			sum_wait_q <= '0;
			sum_turn_q <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (s_tuser == srtf_pkg::CMD_ADD) begin
							if (!table_full) begin
								task_count_q <= task_count_q + CNT_W'(1);
								if (in_burst != '0) begin
									open_count_q <= open_count_q + CNT_W'(1);
								end
							end
							state_q <= S_DONE;
						end else if (open_count_q == '0) begin
							state_q <= S_DONE;
						end else begin
							search_cnt_q <= '0;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					search_cnt_q <= search_cnt_q + IDX_W'(1);
					if (search_cnt_q == IDX_W'(MAX_TASKS - 1)) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					found_q <= chain_tok[MAX_TASKS].found;
					state_q <= S_ADV;
				end
				S_ADV: begin
					clock_q <= clock_next;
					if (found_q && (left_new_q == '0)) begin
						state_q <= S_TURN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TURN: begin
					open_count_q <= open_count_q - CNT_W'(1);
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_wait_q <= wait_sum[srtf_pkg::SUM_W] ? '1
						: wait_sum[srtf_pkg::SUM_W-1:0];
					sum_turn_q <= turn_sum[srtf_pkg::SUM_W] ? '1
						: turn_sum[srtf_pkg::SUM_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result fields built up while the item is worked on.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_q <= clock_q;
			res_idx_q <= '0;
			res_slice_q <= '0;
			res_left_q <= '0;
			res_wait_q <= '0;
			res_turn_q <= '0;
			if (s_tuser == srtf_pkg::CMD_ADD) begin
				res_status_q <= table_full ? srtf_pkg::ST_FULL : srtf_pkg::ST_ADDED;
				if (!table_full) begin
					res_idx_q <= task_count_q[IDX_W-1:0];
				end
			end else begin
				res_status_q <= srtf_pkg::ST_ALL_DONE;
			end
		end
		if (state_q == S_RUN) begin
			best_arr_q <= chain_tok[MAX_TASKS].arrival;
			best_burst_q <= chain_tok[MAX_TASKS].burst;
			if (chain_tok[MAX_TASKS].found) begin
				run_q <= run_d;
				left_new_q <= chain_tok[MAX_TASKS].left - srtf_pkg::BURST_W'(run_d);
				res_idx_q <= chain_idx[MAX_TASKS];
			end else begin
				run_q <= srtf_pkg::QUANTUM_W'(1);
				left_new_q <= '0;
			end
		end
		if (state_q == S_ADV) begin
			if (found_q) begin
				res_slice_q <= run_q;
				res_left_q <= left_new_q;
				res_status_q <= (left_new_q == '0) ? srtf_pkg::ST_FINISHED
					: srtf_pkg::ST_PREEMPTED;
			end else begin
				res_status_q <= srtf_pkg::ST_IDLE_TICK;
			end
		end
		if (state_q == S_TURN) begin
			res_turn_q <= clock_q - best_arr_q;
		end
		if (state_q == S_WAIT) begin
			if (res_turn_q >= srtf_pkg::CLOCK_W'(best_burst_q)) begin
				res_wait_q <= res_turn_q - srtf_pkg::CLOCK_W'(best_burst_q);
			end else begin
				res_wait_q <= '0;
			end
		end
	end

	// Output register: loaded when the item completes, held until the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_tuser_q <= res_status_q;
			out_tdata_q <= {3'b000, sum_turn_q, sum_wait_q,
				srtf_pkg::UNFINISHED_W'(open_count_q), res_turn_q, res_wait_q,
				res_left_q, res_slice_q, start_q,
				srtf_pkg::TASK_INDEX_W'(res_idx_q)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_tdata_q;
	assign m_tuser = out_tuser_q;

	// Unfinished tasks can never outnumber the filled slots.
	a_open_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		open_count_q <= task_count_q)
		else $error("unfinished count exceeds task count");

	// The scheduler clock never runs backward.
	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (clock_q >= $past(clock_q)))
		else $error("clock went backward");

	// A finished result always reports no time left.
	a_finish_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == srtf_pkg::ST_FINISHED)) |-> (m_tdata[61:46] == '0))
		else $error("finished task reports time left");

	// The run stage follows only a complete walk of the cell row.
	a_run_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> ($past(state_q) == S_SEARCH))
		else $error("run stage entered without a search");

endmodule

[src/srtf_cell.sv]
// One table slot of the scheduler with its stage of the minimum search chain.
module srtf_cell #(
	parameter int IDX_W = 6,
	parameter int CNT_W = 7,
	parameter int MY_IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input srtf_pkg::cell_cmd_t cmd,
	input logic [IDX_W-1:0] cmd_idx,
	input logic [CNT_W-1:0] task_count,
	input logic [srtf_pkg::CLOCK_W-1:0] clock_ticks,
	input srtf_pkg::token_t tok_in,
	input logic [IDX_W-1:0] idx_in,
	output srtf_pkg::token_t tok_out,
	output logic [IDX_W-1:0] idx_out
);

	logic [srtf_pkg::ARRIVAL_W-1:0] arrival_q;
	logic [srtf_pkg::BURST_W-1:0] burst_q;
	logic [srtf_pkg::BURST_W-1:0] left_q;
	srtf_pkg::token_t tok_q;
	logic [IDX_W-1:0] idx_q;
	logic eligible;
	logic take;

	// Slot contents are written by an add or by the update after a run.
	always_ff @(posedge clk) begin
		if (cmd.en && (cmd_idx == IDX_W'(MY_IDX))) begin
			left_q <= cmd.left;
			if (cmd.load) begin
				arrival_q <= cmd.arrival;
				burst_q <= cmd.burst;
			end
		end
	end

	// A slot competes when it is filled, unfinished and has arrived.
	// A strict compare keeps the earlier slot on a tie.
	always_comb begin
		eligible = (CNT_W'(MY_IDX) < task_count) && (left_q != '0)
			&& (arrival_q <= clock_ticks);
		take = eligible && (!tok_in.found || (left_q < tok_in.left));
	end

	// Registered hand-off of the best candidate so far to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			tok_q.found <= 1'b1;
			tok_q.left <= left_q;
			tok_q.arrival <= arrival_q;
			tok_q.burst <= burst_q;
			idx_q <= IDX_W'(MY_IDX);
		end else begin
			tok_q <= tok_in;
			idx_q <= idx_in;
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule
